// File: rtl/core/rdf_pkg.sv
// Shared types and constants for the rational difference filter.
`timescale 1ns / 1ps
package rdf_pkg;
   localparam int MAX_ORDER = 8;
   localparam int NCOEF = MAX_ORDER + 1;
   localparam int IDX_W = 4;
   localparam int ACC_W = 72;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   typedef enum logic [1:0] {
      OP_FILTER = 2'd0,
      OP_COEF = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      REG_NUM_LEN = 1'b0,
      REG_DEN_LEN = 1'b1
   } reg_type;

   typedef enum logic [2:0] {ST_IDLE, ST_NUM, ST_DEN, ST_DIV, ST_WAIT, ST_OUT} state_type;

   typedef struct packed {
      logic start;
      logic [ACC_W-1:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [31:0] quot;
      logic ovf;
   } div_rsp_type;
endpackage

// File: rtl/core/rdf_divider.sv
// Radix-2 restoring signed divider with Q16.16 saturation.
`timescale 1ns / 1ps
module rdf_divider
   import rdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [ACC_W-1:0] num_ff, num_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dmag_ff, dmag_in;
   logic [39:0] q_ff, q_in;
   logic neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic big_ff, big_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [33:0] trial;
   logic big;

   assign trial = {rem_ff, num_ff[ACC_W-1]} - {2'b0, dmag_ff};

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; dmag_in = dmag_ff; q_in = q_ff;
      neg_in = neg_ff; busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      big_in = big_ff;
      if (req.start) begin
         num_in = req.dividend[ACC_W-1] ? (~req.dividend + 1'b1) : req.dividend;
         dmag_in = req.divisor[31] ? (~req.divisor + 1'b1) : req.divisor;
         neg_in = req.dividend[ACC_W-1] ^ req.divisor[31];
         rem_in = '0; q_in = '0; busy_in = 1'b1; cnt_in = 7'(ACC_W);
         big_in = 1'b0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         big_in = big_ff | q_ff[39];
         if (!trial[33]) begin
            rem_in = trial[32:0];
            q_in = {q_ff[38:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], num_ff[ACC_W-1]};
            q_in = {q_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in; rem_ff <= rem_in; dmag_ff <= dmag_in; q_ff <= q_in;
      neg_ff <= neg_in; cnt_ff <= cnt_in; big_ff <= big_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign big = big_ff || (|q_ff[39:32]);
   always_comb begin
      rsp.done = done_ff;
      if (!neg_ff) begin
         rsp.ovf = big || q_ff[31];
         rsp.quot = rsp.ovf ? 32'h7FFF_FFFF : q_ff[31:0];
      end else begin
         rsp.ovf = big || (q_ff[31:0] > 32'h8000_0000);
         rsp.quot = rsp.ovf ? 32'h8000_0000 : (32'd0 - q_ff[31:0]);
      end
   end
endmodule

// File: rtl/core/rational_difference_filter.sv
// Top level of the rational difference filter.
// One request is handled at a time; coefficient and clear ops complete when they are transferred.
// The single 32x32 multiply-accumulate unit and the bit-serial divider set the rate.
// Reset: synchronous; coefficients return to 1.0 at entry 0, histories clear, lengths go to 1.
`timescale 1ns / 1ps
module rational_difference_filter
   import rdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // sample_in[31:0], coef_index[35:32], coef_value[67:36]
   input  logic [2:0]  req_tuser,  // op[1:0], coef_bank[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // filtered_out[31:0]
   output logic [1:0]  rsp_tuser,  // overflow_flag[0], error_flag[1]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   state_type state_ff, state_in;
   logic [3:0] nlen_ff, dlen_ff;
   logic [31:0] num_ff [NCOEF];
   logic [31:0] den_ff [NCOEF];
   logic [31:0] xh_ff [MAX_ORDER];
   logic [31:0] yh_ff [MAX_ORDER];
   logic [31:0] x_ff;
   logic [3:0] i_ff, i_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [63:0] prod_ff;
   logic pv_ff, pv_in, psub_ff, psub_in;
   logic [33:0] out_ff;
   logic [31:0] ma, mb;
   logic [3:0] dly;
   logic bad;
   op_type op;
   div_req_type dreq;
   div_rsp_type drsp;
   logic csr_wr;

   assign op = op_type'(req_tuser[1:0]);
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_DEN_LEN) ? {28'd0, dlen_ff} : {28'd0, nlen_ff};
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = out_ff[31:0];
   assign rsp_tuser = out_ff[33:32];
   assign bad = nlen_ff == 4'd0 || dlen_ff == 4'd0 || nlen_ff > 4'(NCOEF)
      || dlen_ff > 4'(NCOEF) || nlen_ff > dlen_ff || den_ff[0] == 32'd0;
   assign dly = i_ff + (dlen_ff - nlen_ff);

   always_comb begin
      if (state_ff == ST_NUM) begin
         ma = num_ff[i_ff];
         mb = (dly == 4'd0) ? x_ff : xh_ff[3'(dly - 4'd1)];
      end else begin
         ma = den_ff[i_ff + 4'd1];
         mb = yh_ff[i_ff[2:0]];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid && op == OP_FILTER) state_in = bad ? ST_OUT : ST_NUM;
         ST_NUM: if (i_ff == nlen_ff - 4'd1) state_in = (dlen_ff == 4'd1) ? ST_DIV : ST_DEN;
         ST_DEN: if (i_ff == dlen_ff - 4'd2) state_in = ST_DIV;
         ST_DIV: if (!pv_ff) state_in = ST_WAIT;
         ST_WAIT: if (drsp.done) state_in = ST_OUT;
         ST_OUT: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      i_in = i_ff; acc_in = acc_ff; pv_in = 1'b0; psub_in = 1'b0;
      dreq.start = 1'b0; dreq.dividend = acc_ff; dreq.divisor = den_ff[0];
      if (pv_ff) acc_in = psub_ff ? acc_ff - ACC_W'($signed(prod_ff))
                                  : acc_ff + ACC_W'($signed(prod_ff));
      case (state_ff)
         ST_IDLE: begin
            i_in = '0; acc_in = '0;
         end
         ST_NUM: begin
            pv_in = 1'b1;
            i_in = (i_ff == nlen_ff - 4'd1) ? 4'd0 : i_ff + 4'd1;
         end
         ST_DEN: begin
            pv_in = 1'b1; psub_in = 1'b1; i_in = i_ff + 4'd1;
         end
         ST_DIV: dreq.start = !pv_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; acc_ff <= acc_in; psub_ff <= psub_in;
      prod_ff <= $signed(ma) * $signed(mb);
      if (reset) begin
         state_ff <= ST_IDLE; pv_ff <= 1'b0; nlen_ff <= 4'd1; dlen_ff <= 4'd1;
         for (int k = 0; k < NCOEF; k++) begin
            num_ff[k] <= (k == 0) ? ONE_Q16 : 32'd0;
            den_ff[k] <= (k == 0) ? ONE_Q16 : 32'd0;
         end
         for (int k = 0; k < MAX_ORDER; k++) begin
            xh_ff[k] <= '0; yh_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in; pv_ff <= pv_in;
         if (csr_wr && csr_paddr[2] == REG_NUM_LEN) nlen_ff <= csr_pwdata[3:0];
         if (csr_wr && csr_paddr[2] == REG_DEN_LEN) dlen_ff <= csr_pwdata[3:0];
         if (req_tvalid && req_tready) begin
            x_ff <= req_tdata[31:0];
            if (op == OP_COEF && req_tdata[35:32] < 4'(NCOEF)) begin
               if (req_tuser[2]) den_ff[req_tdata[35:32]] <= req_tdata[67:36];
               else num_ff[req_tdata[35:32]] <= req_tdata[67:36];
            end
            if (op == OP_CLEAR)
               for (int k = 0; k < MAX_ORDER; k++) begin
                  xh_ff[k] <= '0; yh_ff[k] <= '0;
               end
            if (op == OP_FILTER && bad) out_ff <= {1'b1, 1'b0, 32'd0};
         end
         if (state_ff == ST_WAIT && drsp.done) begin
            out_ff <= {1'b0, drsp.ovf, drsp.quot};
            for (int k = MAX_ORDER - 1; k > 0; k--) begin
               xh_ff[k] <= xh_ff[k-1]; yh_ff[k] <= yh_ff[k-1];
            end
            xh_ff[0] <= x_ff; yh_ff[0] <= drsp.quot;
         end
      end
   end

   rdf_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while result pending");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tdata == 32'd0)
      else $error("error result not zero");
endmodule

// File: sim/testbench.sv
// Self-checking testbench for the rational difference filter: coefficient writes, filtering, errors.
`timescale 1ns / 1ps
module testbench;
   import rdf_pkg::*;

   class iir_predictor;
      logic [31:0] num_coefs [NCOEF];
      logic [31:0] den_coefs [NCOEF];
      logic [31:0] x_hist [MAX_ORDER];
      logic [31:0] y_hist [MAX_ORDER];
      int unsigned num_len;
      int unsigned den_len;
      logic [33:0] expected_outputs [$];
      int mismatches;
      int filtered;
      int flagged;

      function new();
         for (int i = 0; i < NCOEF; i++) begin
            num_coefs[i] = '0;
            den_coefs[i] = '0;
         end
         num_coefs[0] = ONE_Q16;
         den_coefs[0] = ONE_Q16;
         clear_history();
         num_len = 1;
         den_len = 1;
         mismatches = 0;
         filtered = 0;
         flagged = 0;
      endfunction

      function void clear_history();
         for (int i = 0; i < MAX_ORDER; i++) begin
            x_hist[i] = '0;
            y_hist[i] = '0;
         end
      endfunction

      function void set_length(reg_type r, logic [31:0] v);
         if (r == REG_NUM_LEN) num_len = v[3:0];
         else den_len = v[3:0];
      endfunction

      function void note_transfer(op_type op, logic [31:0] x, logic bank, logic [3:0] idx,
                                  logic [31:0] cv);
         logic signed [127:0] acc;
         logic signed [127:0] fa;
         logic signed [127:0] fb;
         logic [127:0] mag;
         logic [127:0] quo;
         logic [31:0] dmag;
         logic [31:0] y;
         logic [31:0] xv;
         logic neg;
         logic ovf;
         int unsigned lag;
         case (op)
            OP_COEF: begin
               if (idx < NCOEF) begin
                  if (bank) den_coefs[idx] = cv;
                  else num_coefs[idx] = cv;
               end
            end
            OP_CLEAR: clear_history();
            OP_FILTER: begin
               filtered++;
               if (num_len == 0 || den_len == 0 || num_len > NCOEF || den_len > NCOEF ||
                   num_len > den_len || den_coefs[0] == 0) begin
                  flagged++;
                  expected_outputs.push_back({1'b1, 1'b0, 32'd0});
                  return;
               end
               acc = '0;
               for (int unsigned i = 0; i < num_len; i++) begin
                  lag = i + den_len - num_len;
                  xv = (lag == 0) ? x : x_hist[(lag - 1) % MAX_ORDER];
                  fa = $signed(num_coefs[i]);
                  fb = $signed(xv);
                  acc = acc + fa * fb;
               end
               for (int unsigned i = 0; i + 1 < den_len; i++) begin
                  fa = $signed(den_coefs[i + 1]);
                  fb = $signed(y_hist[i]);
                  acc = acc - fa * fb;
               end
               mag = acc[127] ? -acc : acc;
               dmag = den_coefs[0][31] ? -den_coefs[0] : den_coefs[0];
               quo = mag / {96'd0, dmag};
               neg = acc[127] ^ den_coefs[0][31];
               ovf = 1'b0;
               if (!neg) begin
                  if (|quo[127:32] || quo[31:0] > 32'h7FFF_FFFF) begin
                     y = 32'h7FFF_FFFF;
                     ovf = 1'b1;
                  end else y = quo[31:0];
               end else begin
                  if (|quo[127:32] || quo[31:0] > 32'h8000_0000) begin
                     y = 32'h8000_0000;
                     ovf = 1'b1;
                  end else y = -quo[31:0];
               end
               if (ovf) flagged++;
               for (int i = MAX_ORDER - 1; i > 0; i--) begin
                  x_hist[i] = x_hist[i - 1];
                  y_hist[i] = y_hist[i - 1];
               end
               x_hist[0] = x;
               y_hist[0] = y;
               expected_outputs.push_back({1'b0, ovf, y});
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [33:0] got);
         logic [33:0] want;
         if (expected_outputs.size() == 0) begin
            $error("unexpected result transfer: %h", got);
            mismatches++;
            return;
         end
         want = expected_outputs.pop_front();
         if (got[31:0] !== want[31:0]) begin
            $error("filtered_out: expected %h actual %h", want[31:0], got[31:0]);
            mismatches++;
         end
         if (got[32] !== want[32]) begin
            $error("overflow_flag: expected %b actual %b", want[32], got[32]);
            mismatches++;
         end
         if (got[33] !== want[33]) begin
            $error("error_flag: expected %b actual %b", want[33], got[33]);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;  // sample_in, coef_index, coef_value, pad
   logic [2:0]  req_tuser = '0;  // op, coef_bank
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;  // filtered_out
   logic [1:0]  rsp_tuser;  // overflow_flag, error_flag
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   iir_predictor sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int nl [11] = '{1, 9, 2, 4, 0, 5, 10, 3, 15, 6, 1};
   int dl [11] = '{1, 9, 4, 4, 3, 2, 12, 9, 15, 7, 9};

   localparam int QUIET_LIMIT = 20000;

   always #5 clock = ~clock;

   rational_difference_filter u_top (.*);

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result({rsp_tuser, rsp_tdata});
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_psel && csr_penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rational_difference_filter regression: fail");
            $finish;
         end
         if (hold_left == 0 && holds_done < holds_asked) begin
            holds_done++;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic csr_write(reg_type r, logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(r) << 2;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      sb.set_length(r, v);
   endtask

   task automatic send(op_type op, logic [31:0] x, logic bank, logic [3:0] idx,
                       logic [31:0] cv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, cv, idx, x};
      req_tuser <= {bank, op};
      do @(posedge clock); while (!req_tready);
      sb.note_transfer(op, x, bank, idx, cv);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_outputs.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_value(bit narrow);
      if (narrow) return 32'($urandom_range(32'h3FFFF)) - 32'h20000;
      return $urandom;
   endfunction

   initial begin
      int pick;
      logic [3:0] idx;
      logic [31:0] v;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      send(OP_FILTER, 32'h0003_0000, 0, 0, 0);
      drain();
      csr_write(REG_NUM_LEN, 3);
      csr_write(REG_DEN_LEN, 3);
      send(OP_COEF, 0, 0, 0, 32'h7FFF_FFFF);
      send(OP_COEF, 0, 0, 1, 32'h8000_0000);
      send(OP_COEF, 0, 0, 2, ONE_Q16);
      send(OP_COEF, 0, 1, 1, 32'h0000_8000);
      send(OP_COEF, 0, 1, 2, 32'hFFFF_C000);
      send(OP_COEF, 0, 1, 9, 32'h1234_5678);
      send(OP_COEF, 0, 0, 15, 32'hFFFF_FFFF);
      send(OP_FILTER, 32'h7FFF_FFFF, 0, 0, 0);
      send(OP_FILTER, 32'h8000_0000, 0, 0, 0);
      send(OP_FILTER, 32'h0000_0000, 1, 15, 32'hFFFF_FFFF);
      send(OP_CLEAR, 32'hFFFF_FFFF, 1, 4, 0);
      send(OP_NONE, 32'h1111_1111, 1, 0, 32'h0001_0000);
      send(OP_FILTER, ONE_Q16, 0, 0, 0);
      send(OP_FILTER, 32'hFFFF_FFFF, 0, 0, 0);
      send(OP_COEF, 0, 1, 0, 32'h0000_0000);
      send(OP_FILTER, ONE_Q16, 0, 0, 0);
      send(OP_COEF, 0, 1, 0, 32'h8000_0000);
      send(OP_FILTER, 32'h0002_0000, 0, 0, 0);
      send(OP_COEF, 0, 1, 0, 32'h0000_0001);
      send(OP_FILTER, 32'h7FFF_0000, 0, 0, 0);
      send(OP_COEF, 0, 1, 0, ONE_Q16);
      send(OP_FILTER, 32'h0000_4000, 0, 0, 0);
      drain();

      for (int p = 0; p < 11; p++) begin
         csr_write(REG_NUM_LEN, nl[p]);
         csr_write(REG_DEN_LEN, dl[p]);
         send_idle_pct = (p < 4) ? 37 : (p < 8) ? 74 : 0;
         recv_idle_pct = (p < 4) ? 74 : (p < 8) ? 37 : 0;
         for (int n = 0; n < 50; n++) begin
            if (p == 2 && n == 10) holds_asked++;
            pick = $urandom_range(99);
            idx = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8));
            if (pick < 65) begin
               send(OP_FILTER, rand_value($urandom_range(3) != 0), 0, 0, 0);
            end else if (pick < 94) begin
               if ($urandom_range(1)) begin
                  if (idx == 0)
                     v = ($urandom_range(15) == 0) ? 32'd0 :
                         ($urandom_range(3) == 0) ? $urandom : ONE_Q16;
                  else
                     v = ($urandom_range(5) == 0) ? $urandom :
                         32'($urandom_range(32'h8000)) - 32'h4000;
                  send(OP_COEF, $urandom, 1, idx, v);
               end else begin
                  send(OP_COEF, $urandom, 0, idx, rand_value($urandom_range(4) != 0));
               end
            end else if (pick < 97) begin
               send(OP_CLEAR, $urandom, 1'($urandom), 4'($urandom), $urandom);
            end else begin
               send(OP_NONE, $urandom, 1'($urandom), 4'($urandom), $urandom);
            end
         end
         drain();
      end

      $display("covered %0d filter results (%0d flagged) across a range of length settings,",
               sb.filtered, sb.flagged);
      $display("with coefficient writes, history clears, idle ops and a long output stall");
      if (sb.mismatches == 0 && sb.expected_outputs.size() == 0)
         $display("rational_difference_filter regression: pass");
      else
         $display("rational_difference_filter regression: fail");
      $finish;
   end
endmodule

// File: rational_difference_filter.f
rtl/core/rdf_pkg.sv
rtl/core/rdf_divider.sv
rtl/core/rational_difference_filter.sv
sim/testbench.sv
